>>> rtl/dust_sensor_low_pulse_occupancy_top_assert.svh
// Assertion macros used by the dust sensor meter top module.
`ifndef DUST_SENSOR_LOW_PULSE_OCCUPANCY_TOP_ASSERT_SVH
`define DUST_SENSOR_LOW_PULSE_OCCUPANCY_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define DSLPO_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define DSLPO_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/dslpo_pkg.sv
// ----------------------------------------------------------------------------
// dslpo_pkg
// Types and constants shared by the low pulse occupancy meter.
// ----------------------------------------------------------------------------
package dslpo_pkg;

  localparam int unsigned NumLanes   = 2;
  localparam logic [19:0] WindowReset = 20'd30000;
  localparam logic [22:0] RatioMax   = 23'd6553600;
  localparam logic [31:0] U32Max     = 32'hFFFF_FFFF;
  // Cubic curve coefficients in fixed point
  localparam logic [3:0]  CoefS3     = 4'd11;
  localparam logic [5:0]  CoefS2     = 6'd38;
  localparam logic [12:0] CoefR      = 13'd5200;
  localparam logic [18:0] CoefC      = 19'd406323;
  // Curve scale 2560 = 512 * 5: shift by 9, then multiply by ceil(2^34 / 5)
  localparam logic [31:0] Recip5     = 32'hCCCC_CCCD;

  localparam logic OpSample  = 1'b0;
  localparam logic OpCollect = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_SUM,
    ST_CDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        op;
    logic        level_p1;
    logic        level_p2;
    logic [31:0] time_us;
    logic [31:0] elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic [31:0] low_time_p1;
    logic [22:0] ratio_p1;
    logic [28:0] conc_p1;
    logic [31:0] low_time_p2;
    logic [22:0] ratio_p2;
    logic [28:0] conc_p2;
  } out_word_t;

  // Control from the sequencer to the lanes
  typedef struct packed {
    logic start;  // load divider operands
    logic div;    // run one divider step
    logic sq;     // clamp ratio
    logic cube;   // form square
    logic sum;    // form cube
    logic cdiv;   // latch curve sum
  } lane_ctl_t;

endpackage

>>> rtl/dslpo_if.sv
// ----------------------------------------------------------------------------
// dslpo_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface dslpo_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/dslpo_lane.sv
// ----------------------------------------------------------------------------
// dslpo_lane
// One channel: pulse timing, saturating total, ratio divide and curve.
// ----------------------------------------------------------------------------
module dslpo_lane
  import dslpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        smp,        // apply one gated sample
  input  logic        level,
  input  logic [31:0] time_us,
  input  logic        clr,        // clear total after collect
  input  logic [23:0] divisor,    // window*10, or 10 when window is zero
  input  lane_ctl_t   ctl,
  output logic [31:0] total,
  output logic [22:0] ratio,
  output logic [28:0] conc
);

  logic        low_active;
  logic [31:0] low_start;
  logic [32:0] sum_wide;
  logic [31:0] diff;

  assign diff     = time_us - low_start;
  assign sum_wide = {1'b0, total} + {1'b0, diff};

  // Track pulse and accumulate low time
  always_ff @(posedge clk) begin
    if (rst) begin
      low_active <= 1'b0;
      low_start  <= '0;
      total      <= '0;
    end else if (smp) begin
      if (!level && !low_active) begin
        low_active <= 1'b1;
        low_start  <= time_us;
      end else if (level && low_active) begin
        low_active <= 1'b0;
        total      <= sum_wide[32] ? U32Max : sum_wide[31:0];
      end
    end else if (clr) begin
      total <= '0;
    end
  end

  // Restoring divider for the ratio: (total << 16) / divisor over 64 steps
  logic [63:0] quo;
  logic [24:0] rem;
  logic [24:0] dvs;
  logic [25:0] trial;
  logic [22:0] r;
  logic [47:0] s2;
  logic [47:0] s3;
  logic [63:0] num;
  logic [39:0] num_q;
  logic [63:0] scaled;

  assign trial = {rem, quo[63]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo <= {16'd0, total, 16'd0};
      rem <= '0;
      dvs <= {1'b0, divisor};
    end else if (ctl.div) begin
      if (!trial[25]) begin
        rem <= trial[24:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[23:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // Quotient sits in quo after 64 steps
  logic [63:0] rq;
  assign rq = quo;

  // Clamp ratio, then square, cube and curve sum, one step per cycle
  always_ff @(posedge clk) begin
    if (ctl.sq) begin
      r  <= (rq > {41'd0, RatioMax}) ? RatioMax : rq[22:0];
    end
    if (ctl.cube) s2 <= ({25'd0, r} * {25'd0, r}) >> 16;
    if (ctl.sum)  s3 <= 48'(({16'd0, s2} * {41'd0, r}) >> 16);
    if (ctl.cdiv) num_q <= num[39:0];
  end

  assign num = {16'd0, s3} * 64'(CoefS3) - {16'd0, s2} * 64'(CoefS2)
             + {41'd0, r} * 64'(CoefR) + 64'(CoefC);

  // Scale by 1/2560: drop 9 bits, then divide by 5 through the reciprocal
  assign scaled = {33'd0, num_q[39:9]} * {32'd0, Recip5};

  assign ratio = r;
  assign conc  = scaled[62:34];

endmodule

>>> rtl/dust_sensor_low_pulse_occupancy_top.sv
// Sample: a sample word is taken in any idle cycle and gives no result.
// Collect: after the accepting edge the 64-step ratio divider runs, then the five
//   clamp, square, cube, sum and scale steps per lane; the result is then registered.
// Both lanes run in parallel; input stalls during a collect, and longer while
//   an earlier result still waits in the output register.
// Reset (rst, synchronous): clears flags, start times, totals; window 30000.
// ----------------------------------------------------------------------------
// dust_sensor_low_pulse_occupancy_top
// Two-channel low pulse occupancy meter with ratio and concentration.
// ----------------------------------------------------------------------------
module dust_sensor_low_pulse_occupancy_top
  import dslpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dslpo_if.sink       in_ch,
  dslpo_if.source     out_ch,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  logic [19:0] window_ms;
  state_t      state, state_next;
  logic [6:0]  cnt;
  lane_ctl_t   ctl;
  in_word_t    iw;
  logic        acc, smp, load_res;
  logic        out_valid;
  logic [23:0] divisor;
  logic [31:0] tot [NumLanes];
  logic [22:0] rat [NumLanes];
  logic [28:0] cnc [NumLanes];
  out_word_t   res;

  assign iw        = in_word_t'(in_ch.data);
  assign cfg_ready = 1'b1;
  assign in_ch.ready = (state == ST_IDLE);
  assign acc = in_ch.valid && in_ch.ready;
  assign smp = acc && (iw.op == OpSample) && (iw.elapsed_ms <= {12'd0, window_ms});
  assign divisor = (window_ms == '0) ? 24'd10 : ({4'd0, window_ms} * 24'd10);
  assign load_res = (state == ST_OUT) && (!out_valid || out_ch.ready);

  // Hold configuration register
  always_ff @(posedge clk) begin
    if (rst) window_ms <= WindowReset;
    else if (cfg_valid && cfg_ready) window_ms <= cfg_data;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (acc && iw.op == OpCollect) state_next = ST_DIV;
      ST_DIV:  if (cnt == 7'd63) state_next = ST_SQ;
      ST_SQ:   state_next = ST_CUBE;
      ST_CUBE: state_next = ST_SUM;
      ST_SUM:  state_next = ST_CDIV;
      ST_CDIV: state_next = ST_OUT;
      ST_OUT:  if (load_res) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ctl       = '0;
    ctl.start = acc && (iw.op == OpCollect);
    ctl.div   = (state == ST_DIV);
    ctl.sq    = (state == ST_SQ);
    ctl.cube  = (state == ST_CUBE);
    ctl.sum   = (state == ST_SUM);
    ctl.cdiv  = (state == ST_CDIV);
  end

  // Advance state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) cnt <= '0;
      else cnt <= cnt + 7'd1;
    end
  end

  // Channel lanes
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    dslpo_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .smp     (smp),
      .level   (g == 0 ? iw.level_p1 : iw.level_p2),
      .time_us (iw.time_us),
      .clr     (ctl.start),
      .divisor (divisor),
      .ctl     (ctl),
      .total   (tot[g]),
      .ratio   (rat[g]),
      .conc    (cnc[g])
    );
  end

  // Capture totals at collect, merge lane results into the output register
  logic [31:0] tot_q [NumLanes];
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      tot_q[0] <= tot[0];
      tot_q[1] <= tot[1];
    end
    if (load_res) begin
      res.low_time_p1 <= tot_q[0];
      res.low_time_p2 <= tot_q[1];
      res.ratio_p1    <= rat[0];
      res.ratio_p2    <= rat[1];
      res.conc_p1     <= cnc[0];
      res.conc_p2     <= cnc[1];
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_res) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = res;

  `include "dust_sensor_low_pulse_occupancy_top_assert.svh"

  `DSLPO_ASSERT_IMP(a_no_in_busy, clk, rst, state != ST_IDLE, !in_ch.ready,
    "input taken while busy")
  `DSLPO_ASSERT_NEXT(a_hold_out, clk, rst, out_ch.valid && !out_ch.ready,
    out_ch.valid, "result dropped")
  `DSLPO_ASSERT_NEXT(a_collect_go, clk, rst, ctl.start, state == ST_DIV,
    "collect did not start")

endmodule
